// ===== sv/ibgd_pkg.sv =====
// ----------------------------------------------------------------------------
// ibgd_pkg
// Shared widths, constants, types and helper functions for the interleaved
// base32 group decoder.
// ----------------------------------------------------------------------------
package ibgd_pkg;

  localparam int CHAR_W      = 8;
  localparam int BYTE_W      = 8;
  localparam int VAL_W       = 5;
  localparam int GROUP_LEN   = 8;
  localparam int GROUP_BYTES = 5;
  localparam int GROUP_BITS  = GROUP_BYTES * BYTE_W;
  localparam int CNT_W       = $clog2(GROUP_LEN);
  localparam int RUN_W       = $clog2(GROUP_BYTES + 1);

  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;   // 'a'
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;  // 'z'
  localparam logic [CHAR_W-1:0] DIGIT_FIRST = 8'd48;   // '0'
  localparam logic [CHAR_W-1:0] DIGIT_LAST  = 8'd53;   // '5'
  localparam logic [CHAR_W-1:0] DIGIT_BIAS  = 8'd22;
  localparam logic [BYTE_W-1:0] MARKER      = 8'h80;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_LEN - 1);
  localparam logic [RUN_W-1:0] RUN_ONE  = RUN_W'(1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(GROUP_BYTES);

  // One pending run of results: up to five bytes, oldest in the top byte.
  typedef struct packed {
    logic [GROUP_BITS-1:0] bytes;
    logic [RUN_W-1:0]      n;
    logic                  bv;
    logic                  done;
    logic                  err;
  } ibgd_slot_t;

  function automatic logic [VAL_W-1:0] ibgd_char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = c;
    if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
      d = c - LOWER_FIRST;
    end else if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
      d = c - DIGIT_BIAS;
    end
    return d[VAL_W-1:0];
  endfunction

  // Bits alternate x4 y4 x3 y3 ... x0 y0, most significant first.
  function automatic logic [2*VAL_W-1:0] ibgd_interleave(input logic [VAL_W-1:0] x,
                                                         input logic [VAL_W-1:0] y);
    logic [2*VAL_W-1:0] r;
    r = '0;
    for (int b = 0; b < VAL_W; b++) begin
      r[2*b+1] = x[b];
      r[2*b]   = y[b];
    end
    return r;
  endfunction

endpackage

// ===== sv/ibgd_in_if.sv =====
// ----------------------------------------------------------------------------
// ibgd_in_if
// Character channel: one encoded character and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface ibgd_in_if;
  import ibgd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

// ===== sv/ibgd_out_if.sv =====
// ----------------------------------------------------------------------------
// ibgd_out_if
// Result channel: one decoded byte with its run and stream status flags.
// ----------------------------------------------------------------------------
interface ibgd_out_if;
  import ibgd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_valid;
  logic              run_last;
  logic              stream_done;
  logic              length_error;

  modport source (output valid, output data_byte, output byte_valid, output run_last,
                  output stream_done, output length_error, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input run_last,
                  input stream_done, input length_error, output ready);
endinterface

// ===== sv/interleaved_base32_group_decoder.sv =====
// ----------------------------------------------------------------------------
// interleaved_base32_group_decoder
// Decodes a stream of base32 characters, eight to a group, into five bytes
// per group with bit-interleaved pairs, trimming the final group at its marker.
// ----------------------------------------------------------------------------
// Output: the item that completes a group or ends the stream writes its result run
//   into the head slot, or into the tail slot while the head slot is occupied.
// Throughput: one character per cycle; a run of up to five bytes drains at one byte per
//   cycle while the output is ready, from a two-slot output buffer, and input
//   stalls only while both slots are occupied.
// Reset: synchronous, clears the group count and both slot valid flags; the
//   stored group values are not reset.
module interleaved_base32_group_decoder (
  input  logic       clk,
  input  logic       rst_n,
  ibgd_in_if.sink    in_ch,
  ibgd_out_if.source out_ch
);
  import ibgd_pkg::*;

  logic [VAL_W-1:0] vals_r [GROUP_LEN-1];
  logic [CNT_W-1:0] count_r, count_nxt;

  ibgd_slot_t head_r, head_nxt;
  ibgd_slot_t tail_r, tail_nxt;
  logic       head_v_r, head_v_nxt;
  logic       tail_v_r, tail_v_nxt;

  logic                  in_acc;
  logic                  full;
  logic                  gen;
  logic                  pop;
  logic                  head_last;
  logic [VAL_W-1:0]      cur_val;
  logic [GROUP_BITS-1:0] grp_bits;
  logic [BYTE_W-1:0]     grp_byte [GROUP_BYTES];
  logic [RUN_W-1:0]      mark_idx;
  ibgd_slot_t            new_s;

  assign in_ch.ready = !tail_v_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_LAST);
  assign gen         = in_acc && (full || in_ch.final_char);
  assign cur_val     = ibgd_char_value(in_ch.char_code);

  assign pop       = head_v_r && out_ch.ready;
  assign head_last = (head_r.n == RUN_ONE);

  // The eighth value comes straight from the incoming character.
  assign grp_bits = {ibgd_interleave(vals_r[0], vals_r[1]),
                     ibgd_interleave(vals_r[2], vals_r[3]),
                     ibgd_interleave(vals_r[4], vals_r[5]),
                     ibgd_interleave(vals_r[6], cur_val)};

  always_comb begin
    for (int i = 0; i < GROUP_BYTES; i++) begin
      grp_byte[i] = grp_bits[GROUP_BITS-1-BYTE_W*i -: BYTE_W];
    end
  end

  // Highest-index byte equal to the marker; zero means none usable.
  always_comb begin
    mark_idx = '0;
    for (int i = 1; i < GROUP_BYTES; i++) begin
      if (grp_byte[i] == MARKER) begin
        mark_idx = RUN_W'(i);
      end
    end
  end

  always_comb begin
    new_s = '0;
    new_s.n = RUN_ONE;
    if (!full) begin
      new_s.done = 1'b1;
      new_s.err  = 1'b1;
    end else if (!in_ch.final_char) begin
      new_s.bytes = grp_bits;
      new_s.n     = RUN_FULL;
      new_s.bv    = 1'b1;
    end else if (mark_idx != '0) begin
      new_s.bytes = grp_bits;
      new_s.n     = mark_idx;
      new_s.bv    = 1'b1;
      new_s.done  = 1'b1;
    end else begin
      new_s.done = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      if (full || in_ch.final_char) begin
        count_nxt = '0;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    head_nxt   = head_r;
    head_v_nxt = head_v_r;
    tail_nxt   = tail_r;
    tail_v_nxt = tail_v_r;
    if (pop) begin
      if (head_last) begin
        head_v_nxt = 1'b0;
      end else begin
        head_nxt.bytes = head_r.bytes << BYTE_W;
        head_nxt.n     = head_r.n - RUN_ONE;
      end
    end
    if (pop && head_last && tail_v_r) begin
      head_nxt   = tail_r;
      head_v_nxt = 1'b1;
      tail_v_nxt = 1'b0;
    end
    if (gen) begin
      if (!head_v_nxt) begin
        head_nxt   = new_s;
        head_v_nxt = 1'b1;
      end else begin
        tail_nxt   = new_s;
        tail_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (in_acc && !full) begin
      vals_r[count_r] <= cur_val;
    end
  end

  assign out_ch.valid        = head_v_r;
  assign out_ch.data_byte    = head_r.bytes[GROUP_BITS-1 -: BYTE_W];
  assign out_ch.byte_valid   = head_r.bv;
  assign out_ch.run_last     = head_last;
  assign out_ch.stream_done  = head_r.done && head_last;
  assign out_ch.length_error = head_r.err;

  a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    tail_v_r |-> head_v_r)
    else $error("tail slot occupied while head slot is empty");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !full && !in_ch.final_char) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("group count did not advance on a mid-group character");

  a_empty_beat_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.byte_valid) |-> (out_ch.run_last && out_ch.stream_done))
    else $error("dataless result is not the end of a stream");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.length_error) |-> !out_ch.byte_valid)
    else $error("length error carried a data byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for interleaved_base32_group_decoder
// Feeds character streams through the input channel with random idle bursts
// and output back-pressure. A scoreboard tracks the group state, predicts every
// decoded byte and its status flags, and checks the results in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ibgd_pkg::*;

  localparam int ITEM_TARGET   = 260;
  localparam int QUIET_TAIL    = 40;
  localparam int LONG_HOLD     = 120;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              bv;
    logic              last;
    logic              done;
    logic              err;
  } decoded_t;

  // Mirrors the group state and keeps the decoded bytes that are still due.
  class group_scoreboard;
    logic [VAL_W-1:0] vals [GROUP_LEN];
    int               fill;
    decoded_t         due_bytes [$];
    int               failures;
    int               checked;
    int               streams;
    int               length_errs;

    function new();
      fill = 0;
      failures = 0;
      checked = 0;
      streams = 0;
      length_errs = 0;
    endfunction

    function logic [VAL_W-1:0] to_value(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = c;
      if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
        d = c - LOWER_FIRST;
      end else if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
        d = c - DIGIT_BIAS;
      end
      return d[VAL_W-1:0];
    endfunction

    function logic [2*VAL_W-1:0] weave(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
      logic [2*VAL_W-1:0] r;
      r = '0;
      for (int b = VAL_W - 1; b >= 0; b--) begin
        r = {r[2*VAL_W-3:0], x[b], y[b]};
      end
      return r;
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic fin);
      logic [GROUP_BITS-1:0] bits;
      logic [BYTE_W-1:0]     b [GROUP_BYTES];
      int                    cut;
      decoded_t              r;
      vals[fill] = to_value(c);
      fill++;
      if (fill < GROUP_LEN) begin
        if (fin) begin
          fill = 0;
          streams++;
          length_errs++;
          r = '{data: '0, bv: 1'b0, last: 1'b1, done: 1'b1, err: 1'b1};
          due_bytes.push_back(r);
        end
        return;
      end
      fill = 0;
      bits = '0;
      for (int i = 0; i < GROUP_LEN / 2; i++) begin
        bits = (bits << (2 * VAL_W)) | GROUP_BITS'(weave(vals[2*i], vals[2*i+1]));
      end
      for (int i = 0; i < GROUP_BYTES; i++) begin
        b[i] = bits[GROUP_BITS-1-BYTE_W*i -: BYTE_W];
      end
      if (!fin) begin
        for (int i = 0; i < GROUP_BYTES; i++) begin
          r = '{data: b[i], bv: 1'b1, last: (i == GROUP_BYTES - 1), done: 1'b0, err: 1'b0};
          due_bytes.push_back(r);
        end
        return;
      end
      streams++;
      // The highest-index marker byte decides where the final group is cut.
      cut = -1;
      for (int n = GROUP_BYTES - 1; n >= 0; n--) begin
        if (cut < 0 && b[n] == MARKER) cut = n;
      end
      if (cut <= 0) begin
        r = '{data: '0, bv: 1'b0, last: 1'b1, done: 1'b1, err: 1'b0};
        due_bytes.push_back(r);
      end else begin
        for (int n = 0; n < cut; n++) begin
          r = '{data: b[n], bv: 1'b1, last: (n == cut - 1), done: (n == cut - 1), err: 1'b0};
          due_bytes.push_back(r);
        end
      end
    endfunction

    function void check_result(decoded_t got);
      decoded_t want;
      checked++;
      if (due_bytes.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("ERROR: unexpected result data=%02h bv=%0b last=%0b done=%0b err=%0b",
                   got.data, got.bv, got.last, got.done, got.err);
        end
        return;
      end
      want = due_bytes.pop_front();
      if (got.data !== want.data || got.bv !== want.bv || got.last !== want.last ||
          got.done !== want.done || got.err !== want.err) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("ERROR: result %0d expected data=%02h bv=%0b last=%0b done=%0b err=%0b",
                   checked, want.data, want.bv, want.last, want.done, want.err);
          $display("       got                data=%02h bv=%0b last=%0b done=%0b err=%0b",
                   got.data, got.bv, got.last, got.done, got.err);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ibgd_in_if  in_ch ();
  ibgd_out_if out_ch ();

  interleaved_base32_group_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  group_scoreboard sb = new();

  bit src_idle_en  = 1'b1;
  bit snk_stall_en = 1'b1;
  bit long_hold_req = 1'b0;
  int chars_sent = 0;
  int watchdog = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts plus one long hold-off on request.
  initial begin : sink_drive
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (snk_stall_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    decoded_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{data: out_ch.data_byte, bv: out_ch.byte_valid, last: out_ch.run_last,
              done: out_ch.stream_done, err: out_ch.length_error};
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog + 1 >= WATCHDOG_MAX) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_code  <= c;
    in_ch.final_char <= fin;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_char(c, fin);
    chars_sent++;
    if (chars_sent >= ITEM_TARGET - QUIET_TAIL) begin
      src_idle_en  = 1'b0;
      snk_stall_en = 1'b0;
    end
  endtask

  // Picks a character for a value; aliases share the low five bits and fall
  // outside both alphabet ranges, so they decode to the same value.
  function automatic logic [CHAR_W-1:0] char_for(input logic [VAL_W-1:0] v, input bit mix);
    logic [CHAR_W-1:0] base;
    if (mix && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0:       base = 8'h00;
        1:       base = 8'h40;
        2:       base = 8'h80;
        3:       base = 8'hA0;
        4:       base = 8'hC0;
        default: base = 8'hE0;
      endcase
      return base | CHAR_W'(v);
    end
    if (v < 26) return LOWER_FIRST + CHAR_W'(v);
    return CHAR_W'(v) + DIGIT_BIAS;
  endfunction

  // Sends the eight characters that decode to the given 40 bits.
  task automatic send_group(input logic [GROUP_BITS-1:0] bits, input logic fin,
                            input bit mix);
    logic [2*VAL_W-1:0] pair;
    logic [VAL_W-1:0]   v;
    for (int j = 0; j < GROUP_LEN; j++) begin
      pair = bits[GROUP_BITS-1-2*VAL_W*(j/2) -: 2*VAL_W];
      for (int b = 0; b < VAL_W; b++) begin
        v[b] = (j % 2 == 0) ? pair[2*b+1] : pair[2*b];
      end
      send_char(char_for(v, mix), fin && (j == GROUP_LEN - 1));
    end
  endtask

  task automatic send_noise(input int count, input logic fin);
    for (int j = 0; j < count; j++) begin
      send_char(CHAR_W'($urandom_range(0, 255)), fin && (j == count - 1));
    end
  endtask

  function automatic logic [GROUP_BITS-1:0] random_bits();
    return {$urandom, 8'($urandom)};
  endfunction

  initial begin : stimulus
    logic [GROUP_BITS-1:0] bits;
    int                    mark;
    int                    kind;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.char_code  <= '0;
    in_ch.final_char <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Character extremes: codes outside the alphabet and both range ends.
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(LOWER_FIRST, 1'b0);
    send_char(LOWER_LAST, 1'b0);
    send_char(DIGIT_FIRST, 1'b0);
    send_char(DIGIT_LAST, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b0);
    // Final group with several markers: the last one sets the cut.
    send_group(40'h00_80_80_12_80, 1'b1, 1'b0);
    // Final group whose only marker is the first byte: no data byte is sent.
    send_group(40'h80_11_22_33_44, 1'b1, 1'b1);
    // A stream that ends after one character.
    send_char(8'hFF, 1'b1);

    // The receiver holds off while the sender keeps offering full groups.
    long_hold_req = 1'b1;
    while (chars_sent < ITEM_TARGET) begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 5) == 0) send_noise(GROUP_LEN, 1'b0);
        else send_group(random_bits(), 1'b0, 1'b1);
      end
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        bits = random_bits();
        mark = $urandom_range(0, GROUP_BYTES) - 1;
        if (mark >= 0) bits[GROUP_BITS-1-BYTE_W*mark -: BYTE_W] = MARKER;
        send_group(bits, 1'b1, 1'b1);
      end else if (kind <= 7) begin
        send_noise($urandom_range(1, GROUP_LEN - 1), 1'b1);
      end else begin
        send_noise(GROUP_LEN, 1'b1);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d characters in %0d streams (%0d ended inside a group).",
             chars_sent, sb.streams, sb.length_errs);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.failures);
    if (sb.failures == 0 && sb.due_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
